// File: rtl/core/lowest_common_ancestor_lifting_top_defines.svh
// Assertion macros for the checker file of the ancestor-lifting block.
// No dependencies; included by bare file name.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_TOP_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_TOP_DEFINES_SVH

// cons checked in the cycle after ante
`define LCAL_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("lcal: next-cycle check failed");

// ante and cons in the same cycle
`define LCAL_ASSERT_SAME(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("lcal: same-cycle check failed");

`endif

// File: rtl/core/lcal_pkg.sv
// Shared types, constants and the microcode table of the ancestor-lifting block.
// No dependencies; used by every module of the block.
package lcal_pkg;

  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;
  localparam int NODE_W     = 10;
  localparam int DEPTH_W    = 10;
  localparam int DIST_W     = 11;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [DIST_W-1:0] distance;
  } out_req_t;

  typedef enum logic [2:0] {
    XS_HOLD, XS_IN, XS_Y, XS_ORDER, XS_LIFT, XS_PAIR, XS_ANC
  } xsel_t;

  typedef enum logic [2:0] {
    YS_HOLD, YS_IN, YS_X, YS_ORDER, YS_PAIR
  } ysel_t;

  typedef enum logic [1:0] {
    DS_HOLD, DS_FIRST, DS_ORDER
  } dsel_t;

  typedef enum logic [2:0] {
    K_HOLD, K_ZERO, K_TOP, K_INC, K_DEC
  } kop_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_GOTO, BR_DISPATCH, BR_WDONE, BR_KZERO, BR_EQ, BR_OUTFREE
  } br_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_ROOT, S_LD_WAIT, S_LD_STEP, S_QD0, S_QD1,
    S_LIFT, S_CMP, S_PAIR, S_PAR, S_EMIT
  } step_t;

  typedef struct packed {
    xsel_t xsel;
    ysel_t ysel;
    dsel_t dsel;
    kop_t  kop;
    logic  wr_depth;
    logic  wr_jump;
    logic  jw_inc;
    logic  emit;
    br_t   br;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic node_ok;
    logic k_zero;
    logic w_done;
    logic xy_eq;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{
    xsel: XS_HOLD, ysel: YS_HOLD, dsel: DS_HOLD, kop: K_HOLD,
    wr_depth: 1'b0, wr_jump: 1'b0, jw_inc: 1'b0, emit: 1'b0,
    br: BR_NEXT, target: S_IDLE
  };

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (s)
      S_IDLE: begin
        c.xsel = XS_IN;
        c.ysel = YS_IN;
        c.kop  = K_ZERO;
        c.br   = BR_DISPATCH;
      end
      S_LD_ROOT: begin
        c.wr_depth = 1'b1;
        c.wr_jump  = 1'b1;
      end
      S_LD_WAIT: begin
        c.br     = BR_WDONE;
        c.target = S_IDLE;
      end
      S_LD_STEP: begin
        c.wr_jump = 1'b1;
        c.jw_inc  = 1'b1;
        c.xsel    = XS_ANC;
        c.kop     = K_INC;
        c.br      = BR_GOTO;
        c.target  = S_LD_WAIT;
      end
      S_QD0: begin
        c.dsel = DS_FIRST;
        c.xsel = XS_Y;
        c.ysel = YS_X;
      end
      S_QD1: begin
        c.dsel = DS_ORDER;
        c.xsel = XS_ORDER;
        c.ysel = YS_ORDER;
        c.kop  = K_TOP;
      end
      S_LIFT: begin
        c.xsel = XS_LIFT;
        c.kop  = K_DEC;
        c.br   = BR_KZERO;
      end
      S_CMP: begin
        c.kop    = K_TOP;
        c.br     = BR_EQ;
        c.target = S_EMIT;
      end
      S_PAIR: begin
        c.xsel = XS_PAIR;
        c.ysel = YS_PAIR;
        c.kop  = K_DEC;
        c.br   = BR_KZERO;
      end
      S_PAR: begin
        c.xsel = XS_ANC;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.br     = BR_OUTFREE;
        c.target = S_IDLE;
      end
      default: begin
        c.br     = BR_GOTO;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/lowest_common_ancestor_lifting_top.sv
// Lowest common ancestor by binary lifting.
// Input channel (in_valid/in_stall/in_data): cmd 0 loads second_node with
// parent first_node (0 = root); cmd 1 queries first_node and second_node.
// Parents must be loaded by the user before their children; the block
// does not enforce it. Node 0 is a fixed sentinel. Result channel
// (out_valid/out_stall/out_data): one request per query, ancestor and
// path distance; loads give no result. A load writes the node's depth
// and parent, then fills the higher levels one by one; a query orders
// its nodes by depth, lifts the deeper one, then lifts both together and
// takes their parent unless they meet, its result showing the cycle after
// its emit step. A new request is taken only while idle, so none is taken
// before the last is through. One lift step per level, each bound by the
// registered read of the ancestor memory; loads add a wait step per level.
// The result sits in an output register: while out_stall holds it, the
// block still takes and loads new requests, and a new query waits in its
// last step until the register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle, holds
// in_stall high and empties the output register; the memories are not
// cleared.
// Depends on lcal_pkg, lcal_seq, lcal_dpath.
module lowest_common_ancestor_lifting_top #(
  parameter int NODES  = lcal_pkg::NODES_DEF,
  parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcal_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lcal_pkg::out_req_t out_data
);

  lcal_pkg::ctrl_t    ctrl;
  lcal_pkg::stat_t    stat;
  lcal_pkg::out_req_t result;
  logic               idle, emit, in_accept, out_free;
  logic               out_valid_r;
  lcal_pkg::out_req_t out_data_r;

  assign in_stall  = !idle || !rst_n;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  lcal_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .out_free  (out_free),
    .stat      (stat),
    .ctrl      (ctrl),
    .idle      (idle),
    .emit      (emit)
  );

  lcal_dpath #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk    (clk),
    .in_req (in_data),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/lcal_dpath.sv
// Datapath: node/level registers, depth and ancestor memories, lift compares.
// Depends on lcal_pkg; driven by the control word of lcal_seq.
module lcal_dpath #(
  parameter int NODES  = lcal_pkg::NODES_DEF,
  parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  lcal_pkg::in_req_t in_req,
  input  lcal_pkg::ctrl_t   ctrl,
  output lcal_pkg::stat_t   stat,
  output lcal_pkg::out_req_t result
);

  localparam int KW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JDEPTH = NODES * LEVELS;
  localparam int JAW    = $clog2(JDEPTH);
  localparam int NAW    = $clog2(NODES);
  localparam int LW     = lcal_pkg::DEPTH_W + LEVELS + 1;
  localparam int NW     = lcal_pkg::NODE_W;
  localparam int DW     = lcal_pkg::DEPTH_W;

  logic [NW-1:0] jump_mem  [JDEPTH];
  logic [DW-1:0] depth_mem [NODES];

  logic [NW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [DW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [NW-1:0] ja_raw_r, jb_raw_r;
  logic [DW-1:0] d_raw_r;

  logic [NW-1:0] ja, jb, first_c, second_c, jw_data;
  logic [DW-1:0] drd, d_new;
  logic [KW-1:0] jw_lvl;
  logic          lift_ok, differ, gt;
  logic [DW+1:0] sum, twice;

  function automatic logic [JAW-1:0] jaddr(logic [NW-1:0] node, logic [KW-1:0] lvl);
    logic [JAW-1:0] a;
    a = JAW'(node) * JAW'(LEVELS) + JAW'(lvl);
    return a;
  endfunction

  // node 0 is the sentinel: depth 0, every ancestor 0
  assign ja  = (x_r == '0) ? '0 : ja_raw_r;
  assign jb  = (y_r == '0) ? '0 : jb_raw_r;
  assign drd = (x_r == '0) ? '0 : d_raw_r;

  assign first_c  = (32'(in_req.first_node) < NODES) ? in_req.first_node : '0;
  assign second_c = (32'(in_req.second_node) < NODES) ? in_req.second_node : '0;

  assign lift_ok = LW'(drd) >= (LW'(dy_r) + (LW'(1) << k_r));
  assign differ  = (ja != jb);
  assign gt      = (drd > dy_r);

  always_comb begin
    unique case (ctrl.xsel)
      lcal_pkg::XS_HOLD:  x_nxt = x_r;
      lcal_pkg::XS_IN:    x_nxt = first_c;
      lcal_pkg::XS_Y:     x_nxt = y_r;
      lcal_pkg::XS_ORDER: x_nxt = gt ? x_r : y_r;
      lcal_pkg::XS_LIFT:  x_nxt = lift_ok ? ja : x_r;
      lcal_pkg::XS_PAIR:  x_nxt = differ ? ja : x_r;
      lcal_pkg::XS_ANC:   x_nxt = ja;
      default:            x_nxt = x_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.ysel)
      lcal_pkg::YS_HOLD:  y_nxt = y_r;
      lcal_pkg::YS_IN:    y_nxt = second_c;
      lcal_pkg::YS_X:     y_nxt = x_r;
      lcal_pkg::YS_ORDER: y_nxt = gt ? y_r : x_r;
      lcal_pkg::YS_PAIR:  y_nxt = differ ? jb : y_r;
      default:            y_nxt = y_r;
    endcase
  end

  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    unique case (ctrl.dsel)
      lcal_pkg::DS_HOLD: ;
      lcal_pkg::DS_FIRST: dy_nxt = drd;
      lcal_pkg::DS_ORDER: begin
        dx_nxt = gt ? drd : dy_r;
        dy_nxt = gt ? dy_r : drd;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (ctrl.kop)
      lcal_pkg::K_HOLD: k_nxt = k_r;
      lcal_pkg::K_ZERO: k_nxt = '0;
      lcal_pkg::K_TOP:  k_nxt = KW'(LEVELS - 1);
      lcal_pkg::K_INC:  k_nxt = k_r + KW'(1);
      lcal_pkg::K_DEC:  k_nxt = (k_r == '0) ? '0 : k_r - KW'(1);
      default:          k_nxt = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    k_r  <= k_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  // load: child depth saturates, root gets depth 0
  assign d_new   = (x_r == '0) ? '0 :
                   (drd == lcal_pkg::DEPTH_MAX) ? lcal_pkg::DEPTH_MAX : drd + DW'(1);
  assign jw_lvl  = ctrl.jw_inc ? k_r + KW'(1) : k_r;
  assign jw_data = ctrl.jw_inc ? ja : x_r;

  // reads follow the next-cycle node/level, so read data matches x_r, y_r, k_r
  always_ff @(posedge clk) begin
    if (ctrl.wr_depth) begin
      depth_mem[NAW'(y_r)] <= d_new;
    end
    d_raw_r <= depth_mem[NAW'(x_nxt)];
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_jump) begin
      jump_mem[jaddr(y_r, jw_lvl)] <= jw_data;
    end
    ja_raw_r <= jump_mem[jaddr(x_nxt, k_nxt)];
    jb_raw_r <= jump_mem[jaddr(y_nxt, k_nxt)];
  end

  assign sum   = (DW+2)'(dx_r) + (DW+2)'(dy_r);
  assign twice = {1'b0, drd, 1'b0};

  assign result.ancestor = x_r;
  assign result.distance = (sum >= twice) ? lcal_pkg::DIST_W'(sum - twice) : '0;

  assign stat.cmd     = in_req.cmd;
  assign stat.node_ok = (in_req.second_node != '0) && (32'(in_req.second_node) < NODES);
  assign stat.k_zero  = (k_r == '0);
  assign stat.w_done  = (32'(k_r) + 32'd1 >= 32'(LEVELS));
  assign stat.xy_eq   = (x_r == y_r);

endmodule

// File: rtl/core/lcal_seq.sv
// Microcode sequencer: step counter, control-word table lookup, branch logic.
// Depends on lcal_pkg (step codes, control word, ucode table).
module lcal_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic            out_free,
  input  lcal_pkg::stat_t stat,
  output lcal_pkg::ctrl_t ctrl,
  output logic            idle,
  output logic            emit
);

  lcal_pkg::step_t upc_r, upc_nxt, upc_inc;

  assign ctrl    = lcal_pkg::ucode(upc_r);
  assign upc_inc = lcal_pkg::step_t'(upc_r + 4'd1);

  always_comb begin
    upc_nxt = upc_r;
    unique case (ctrl.br)
      lcal_pkg::BR_NEXT: upc_nxt = upc_inc;
      lcal_pkg::BR_GOTO: upc_nxt = ctrl.target;
      lcal_pkg::BR_DISPATCH: begin
        priority if (!in_accept) begin
          upc_nxt = upc_r;
        end else if (stat.cmd == lcal_pkg::CMD_QUERY) begin
          upc_nxt = lcal_pkg::S_QD0;
        end else if (stat.node_ok) begin
          upc_nxt = lcal_pkg::S_LD_ROOT;
        end else begin
          upc_nxt = lcal_pkg::S_IDLE;
        end
      end
      lcal_pkg::BR_WDONE:   upc_nxt = stat.w_done ? ctrl.target : upc_inc;
      lcal_pkg::BR_KZERO:   upc_nxt = stat.k_zero ? upc_inc : upc_r;
      lcal_pkg::BR_EQ:      upc_nxt = stat.xy_eq ? ctrl.target : upc_inc;
      lcal_pkg::BR_OUTFREE: upc_nxt = out_free ? ctrl.target : upc_r;
      default:              upc_nxt = lcal_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idle = (upc_r == lcal_pkg::S_IDLE);
    emit = ctrl.emit && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= lcal_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: rtl/core/lcal_chk.sv
// Port-level checker for the ancestor-lifting top, attached by bind.
// Depends on lcal_pkg and lowest_common_ancestor_lifting_top_defines.svh.
`include "lowest_common_ancestor_lifting_top_defines.svh"

module lcal_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lcal_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lcal_pkg::out_req_t out_data
);

  `LCAL_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `LCAL_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid)
  `LCAL_ASSERT_NEXT(a_query_busy, clk, !rst_n, in_valid && !in_stall && in_data.cmd == lcal_pkg::CMD_QUERY, in_stall)
  `LCAL_ASSERT_SAME(a_result_from_busy, clk, !rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind lowest_common_ancestor_lifting_top lcal_chk u_lcal_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
